>>> rtl/core/periodic_frame_injection_table_top_defines.svh
`ifndef PERIODIC_FRAME_INJECTION_TABLE_TOP_DEFINES_SVH
`define PERIODIC_FRAME_INJECTION_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define PFIT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PFIT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pfit_pkg.sv
package pfit_pkg;

  localparam int JobSlotsDef    = 8;
  localparam int MaxDlc         = 8;
  localparam int QueueDepth     = 2;
  localparam logic [15:0] MinIntervalRst = 16'd10;

  typedef enum logic [1:0] {
    ACT_SET       = 2'd0,
    ACT_CLEAR     = 2'd1,
    ACT_CLEAR_ALL = 2'd2,
    ACT_TICK      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_SET       = 2'd0,
    KIND_CLEAR     = 2'd1,
    KIND_TX        = 2'd2,
    KIND_TICK_DONE = 2'd3
  } kind_e;

  // Command after clamping, as it travels from front to back.
  typedef struct packed {
    action_e      action;
    logic [28:0]  id;
    logic         ext;
    logic [3:0]   len;
    logic [63:0]  data;
    logic [31:0]  interval;
    logic [31:0]  rpt;
    logic [31:0]  now;
  } cmd_t;

  typedef struct packed {
    kind_e        kind;
    logic         acc;
    logic [28:0]  id;
    logic         ext;
    logic [3:0]   len;
    logic [63:0]  data;
    logic [3:0]   cnt;
    logic         last;
  } res_t;

endpackage

>>> rtl/core/pfit_if.sv
interface pfit_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [28:0]        frame_id;
  logic               extended_flag;
  logic [3:0]         length_code;
  logic [63:0]        payload;
  logic [31:0]        period_ms;
  logic signed [31:0] repeat_count;
  logic [31:0]        now_ms;

  modport source (output valid, action, frame_id, extended_flag, length_code, payload,
                  period_ms, repeat_count, now_ms, input ready);
  modport sink (input valid, action, frame_id, extended_flag, length_code, payload,
                period_ms, repeat_count, now_ms, output ready);
endinterface

interface pfit_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic        accepted;
  logic [28:0] tx_id;
  logic        tx_extended;
  logic [3:0]  tx_length;
  logic [63:0] tx_payload;
  logic [3:0]  active_jobs;
  logic        last_of_run;

  modport source (output valid, result_kind, accepted, tx_id, tx_extended, tx_length,
                  tx_payload, active_jobs, last_of_run, input ready);
  modport sink (input valid, result_kind, accepted, tx_id, tx_extended, tx_length,
                tx_payload, active_jobs, last_of_run, output ready);
endinterface

interface pfit_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/pfit_front.sv
module pfit_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  pfit_in_if.sink       in_i,
  pfit_cfg_if.sink      cfg_i,
  output logic          push_valid_o,
  output pfit_pkg::cmd_t push_cmd_o,
  input  logic          push_ready_i
);

  logic [15:0] min_iv_q;
  logic [3:0]  len_c;
  logic [31:0] iv_c;
  logic [63:0] data_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_iv_q <= pfit_pkg::MinIntervalRst;
    end else if (cfg_i.valid) begin
      min_iv_q <= cfg_i.data;
    end
  end

  assign cfg_i.ready = 1'b1;

  always_comb begin
    len_c = (in_i.length_code > 4'(pfit_pkg::MaxDlc)) ? 4'(pfit_pkg::MaxDlc)
                                                      : in_i.length_code;
    iv_c  = (in_i.period_ms < {16'd0, min_iv_q}) ? {16'd0, min_iv_q} : in_i.period_ms;
    // bytes at and past the length go to zero
    for (int b = 0; b < 8; b++) begin
      data_c[8*b +: 8] = (4'(b) < len_c) ? in_i.payload[8*b +: 8] : 8'd0;
    end
  end

  assign push_valid_o        = in_i.valid;
  assign in_i.ready          = push_ready_i;
  assign push_cmd_o.action   = pfit_pkg::action_e'(in_i.action);
  assign push_cmd_o.id       = in_i.frame_id;
  assign push_cmd_o.ext      = in_i.extended_flag;
  assign push_cmd_o.len      = len_c;
  assign push_cmd_o.data     = data_c;
  assign push_cmd_o.interval = iv_c;
  assign push_cmd_o.rpt      = in_i.repeat_count;
  assign push_cmd_o.now      = in_i.now_ms;

endmodule

>>> rtl/core/pfit_queue.sv
module pfit_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  pfit_pkg::cmd_t push_cmd_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output pfit_pkg::cmd_t pop_cmd_o,
  input  logic           pop_ready_i
);

  localparam int Depth = pfit_pkg::QueueDepth;
  localparam int PW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = $clog2(Depth + 1);

  pfit_pkg::cmd_t mem_q [Depth];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;
  logic           push, pop;

  assign push_ready_o = (cnt_q != CW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/pfit_back.sv
module pfit_back #(
  parameter int JobSlots = pfit_pkg::JobSlotsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  pfit_pkg::cmd_t pop_cmd_i,
  output logic           pop_ready_o,
  pfit_out_if.source     out_o
);

  localparam int IW = (JobSlots > 1) ? $clog2(JobSlots) : 1;
  localparam int CW = $clog2(JobSlots + 1);
  localparam logic [IW-1:0] LastIdx = IW'(JobSlots - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_e;

  state_e         state_q;
  logic [IW-1:0]  idx_q, match_idx_q, free_idx_q;
  logic           match_q, free_q;
  logic [CW-1:0]  cnt_q;
  logic [JobSlots-1:0] active_q;
  pfit_pkg::cmd_t cmd_q;
  pfit_pkg::res_t res_q;
  logic           ov_q;

  logic [28:0] s_id   [JobSlots];
  logic        s_ext  [JobSlots];
  logic [3:0]  s_len  [JobSlots];
  logic [63:0] s_data [JobSlots];
  logic [31:0] s_int  [JobSlots];
  logic [31:0] s_last [JobSlots];
  logic [31:0] s_rem  [JobSlots];

  logic          can_load, cur_act, id_hit, due, counting, expire, set_ok, load_res;
  logic [31:0]   elapsed, rem;
  logic [IW-1:0] wr_slot;
  logic [CW-1:0] cnt_dec, cnt_inc;
  pfit_pkg::res_t res_fin;

  assign can_load = !ov_q || out_o.ready;
  assign cur_act  = active_q[idx_q];
  assign id_hit   = (s_id[idx_q] == cmd_q.id);
  assign elapsed  = cmd_q.now - s_last[idx_q];
  // never-sent mark is a stored time of zero
  assign due      = cur_act && ((s_last[idx_q] == 32'd0) || (elapsed >= s_int[idx_q]));
  assign rem      = s_rem[idx_q];
  assign counting = (rem != 32'd0) && !rem[31];
  assign expire   = counting && (rem == 32'd1);
  assign set_ok   = match_q || free_q;
  assign wr_slot  = match_q ? match_idx_q : free_idx_q;
  assign cnt_dec  = cnt_q - CW'(1);
  assign cnt_inc  = cnt_q + CW'(1);
  assign pop_ready_o = (state_q == ST_IDLE);
  // a beat goes into the result register this cycle
  assign load_res = can_load &&
                    ((state_q == ST_FIN) ||
                     (state_q == ST_SCAN && cmd_q.action == pfit_pkg::ACT_TICK && due));

  // closing beat of a command
  always_comb begin
    res_fin = '{kind: pfit_pkg::KIND_CLEAR, acc: 1'b0, id: '0, ext: 1'b0,
                len: '0, data: '0, cnt: 4'(cnt_q), last: 1'b1};
    case (cmd_q.action)
      pfit_pkg::ACT_SET: begin
        res_fin.kind = pfit_pkg::KIND_SET;
        res_fin.acc  = set_ok;
        if (set_ok && !match_q) begin
          res_fin.cnt = 4'(cnt_inc);
        end
      end
      pfit_pkg::ACT_TICK: res_fin.kind = pfit_pkg::KIND_TICK_DONE;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN && cmd_q.action == pfit_pkg::ACT_TICK && due && can_load) begin
      s_last[idx_q] <= (cmd_q.now == 32'd0) ? 32'd1 : cmd_q.now;
      if (counting) begin
        s_rem[idx_q] <= rem - 32'd1;
      end
    end
    if (state_q == ST_FIN && cmd_q.action == pfit_pkg::ACT_SET && set_ok && can_load) begin
      s_id[wr_slot]   <= cmd_q.id;
      s_ext[wr_slot]  <= cmd_q.ext;
      s_len[wr_slot]  <= cmd_q.len;
      s_data[wr_slot] <= cmd_q.data;
      s_int[wr_slot]  <= cmd_q.interval;
      s_last[wr_slot] <= 32'd0;
      s_rem[wr_slot]  <= cmd_q.rpt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      match_idx_q <= '0;
      free_idx_q  <= '0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      cnt_q       <= '0;
      active_q    <= '0;
      cmd_q       <= '0;
      res_q       <= '0;
      ov_q        <= 1'b0;
    end else begin
      ov_q <= load_res || (ov_q && !out_o.ready);
      case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            cmd_q   <= pop_cmd_i;
            idx_q   <= '0;
            match_q <= 1'b0;
            free_q  <= 1'b0;
            if (pop_cmd_i.action == pfit_pkg::ACT_CLEAR_ALL) begin
              active_q <= '0;
              cnt_q    <= '0;
              state_q  <= ST_FIN;
            end else begin
              state_q  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (cmd_q.action != pfit_pkg::ACT_TICK || !due || can_load) begin
            if (idx_q == LastIdx) begin
              state_q <= ST_FIN;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
          case (cmd_q.action)
            pfit_pkg::ACT_SET: begin
              if (cur_act && id_hit && !match_q) begin
                match_q     <= 1'b1;
                match_idx_q <= idx_q;
              end
              if (!cur_act && !free_q) begin
                free_q     <= 1'b1;
                free_idx_q <= idx_q;
              end
            end
            pfit_pkg::ACT_CLEAR: begin
              if (cur_act && id_hit) begin
                active_q[idx_q] <= 1'b0;
                cnt_q           <= cnt_dec;
              end
            end
            pfit_pkg::ACT_TICK: begin
              if (due && can_load) begin
                res_q <= '{kind: pfit_pkg::KIND_TX, acc: 1'b0, id: s_id[idx_q],
                           ext: s_ext[idx_q], len: s_len[idx_q], data: s_data[idx_q],
                           cnt: 4'(expire ? cnt_dec : cnt_q), last: 1'b0};
                if (expire) begin
                  active_q[idx_q] <= 1'b0;
                  cnt_q           <= cnt_dec;
                end
              end
            end
            default: begin
            end
          endcase
        end
        ST_FIN: begin
          if (can_load) begin
            state_q <= ST_IDLE;
            res_q   <= res_fin;
            if (cmd_q.action == pfit_pkg::ACT_SET && set_ok && !match_q) begin
              active_q[wr_slot] <= 1'b1;
              cnt_q             <= cnt_inc;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.result_kind = res_q.kind;
  assign out_o.accepted    = res_q.acc;
  assign out_o.tx_id       = res_q.id;
  assign out_o.tx_extended = res_q.ext;
  assign out_o.tx_length   = res_q.len;
  assign out_o.tx_payload  = res_q.data;
  assign out_o.active_jobs = res_q.cnt;
  assign out_o.last_of_run = res_q.last;

endmodule

>>> rtl/core/periodic_frame_injection_table_top.sv
// Periodic CAN transmit job table.
// in_i carries commands: set job, clear by identifier, clear all, and the
// millisecond tick. out_o returns result beats: one set or clear response per
// command; per tick one frame beat for every due job in slot order, then a
// tick-finished beat. last_of_run marks the final beat of each command.
// cfg_i writes the minimum repeat interval; it is always ready. The user must
// see that it is written only while the table is idle; the block itself does
// not enforce this. A front stage clamps length and interval and masks the
// payload into a two-entry command queue; the back end walks the slots, one
// per cycle while out_o does not stall it, from the idle state through the
// scan to the closing state, which loads the closing beat; a clear all goes
// straight from idle to the closing state. The frame beat of a due slot goes
// into the result register as the scan reaches that slot.
// A new command is taken into the queue while the back end works.
// A stalled out_o holds the result register; the slot walk stops at the next
// beat it must load, the queue fills and then in_i.ready drops.
// Reset empties the queue, deactivates every slot and sets the minimum
// interval to 10. Slot contents are not reset.
module periodic_frame_injection_table_top #(
  parameter int JOB_SLOTS = pfit_pkg::JobSlotsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfit_in_if.sink    in_i,
  pfit_cfg_if.sink   cfg_i,
  pfit_out_if.source out_o
);

  logic           push_valid, push_ready, pop_valid, pop_ready;
  pfit_pkg::cmd_t push_cmd, pop_cmd;

  pfit_front u_front (
    .clk_i, .rst_ni, .in_i, .cfg_i,
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  pfit_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  pfit_back #(.JobSlots(JOB_SLOTS)) u_back (
    .clk_i, .rst_ni,
    .pop_valid_i (pop_valid),
    .pop_cmd_i   (pop_cmd),
    .pop_ready_o (pop_ready),
    .out_o
  );

endmodule

>>> rtl/core/pfit_checker.sv
`include "periodic_frame_injection_table_top_defines.svh"

module pfit_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic        out_acc_i,
  input logic [28:0] out_id_i,
  input logic [3:0]  out_len_i,
  input logic [63:0] out_data_i,
  input logic        out_last_i
);

  `PFIT_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_kind_i) && $stable(out_data_i), "result beat changed under stall")
  `PFIT_ASSERT_IMP(a_last, clk_i, rst_ni, out_valid_i, out_last_i == (out_kind_i != pfit_pkg::KIND_TX), "last flag does not match kind")
  `PFIT_ASSERT_IMP(a_acc, clk_i, rst_ni, out_valid_i && out_kind_i != pfit_pkg::KIND_SET, !out_acc_i, "accepted set outside set response")
  `PFIT_ASSERT_IMP(a_zero, clk_i, rst_ni, out_valid_i && out_kind_i != pfit_pkg::KIND_TX, out_id_i == '0 && out_len_i == '0 && out_data_i == '0, "frame fields not zero")
  `PFIT_ASSERT_IMP(a_len, clk_i, rst_ni, out_valid_i && out_kind_i == pfit_pkg::KIND_TX, out_len_i <= 4'(pfit_pkg::MaxDlc), "frame length above 8")

endmodule

bind periodic_frame_injection_table_top pfit_checker u_pfit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.result_kind),
  .out_acc_i   (out_o.accepted),
  .out_id_i    (out_o.tx_id),
  .out_len_i   (out_o.tx_length),
  .out_data_i  (out_o.tx_payload),
  .out_last_i  (out_o.last_of_run)
);

>>> tb/sv/periodic_frame_injection_table_top_tb.sv
module periodic_frame_injection_table_top_tb;

  typedef struct packed {
    pfit_pkg::action_e action;
    logic [28:0] id;
    logic        ext;
    logic [3:0]  len;
    logic [63:0] data;
    logic [31:0] interval;
    logic [31:0] rpt;
    logic [31:0] now;
  } job_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pfit_in_if  in_if();
  pfit_out_if out_if();
  pfit_cfg_if cfg_if();

  periodic_frame_injection_table_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic [15:0] min_iv;
  logic        tab_act [8];
  logic [28:0] tab_id  [8];
  logic        tab_ext [8];
  logic [3:0]  tab_len [8];
  logic [63:0] tab_data[8];
  logic [31:0] tab_iv  [8];
  logic [31:0] tab_sent[8];
  logic [31:0] tab_rem [8];

  job_cmd_t       cmd_q[$];
  pfit_pkg::res_t exp_q[$];
  int             errors = 0;
  int             sent_cnt = 0;

  function automatic logic [3:0] live_jobs();
    logic [3:0] n;
    n = 0;
    for (int i = 0; i < 8; i++) if (tab_act[i]) n++;
    return n;
  endfunction

  function automatic void push_res(pfit_pkg::kind_e k, logic acc, logic [28:0] id, logic ext,
                                   logic [3:0] len, logic [63:0] d, logic last);
    pfit_pkg::res_t r;
    r.kind = k; r.acc = acc; r.id = id; r.ext = ext; r.len = len; r.data = d;
    r.cnt = live_jobs(); r.last = last;
    exp_q.push_back(r);
  endfunction

  function automatic void predict_table(job_cmd_t c);
    int slot;
    logic [3:0] len;
    logic [31:0] iv;
    logic [63:0] mask;
    slot = -1;
    case (c.action)
      pfit_pkg::ACT_SET: begin
        len = (c.len > 4'd8) ? 4'd8 : c.len;
        iv = (c.interval < {16'd0, min_iv}) ? {16'd0, min_iv} : c.interval;
        for (int i = 0; i < 8; i++)
          if (slot < 0 && tab_act[i] && tab_id[i] == c.id) slot = i;
        for (int i = 0; i < 8; i++)
          if (slot < 0 && !tab_act[i]) slot = i;
        if (slot >= 0) begin
          mask = (len >= 8) ? '1 : ((64'd1 << (len * 8)) - 64'd1);
          tab_id[slot] = c.id; tab_ext[slot] = c.ext; tab_len[slot] = len;
          tab_data[slot] = c.data & mask; tab_iv[slot] = iv; tab_sent[slot] = 0;
          tab_rem[slot] = c.rpt; tab_act[slot] = 1'b1;
        end
        push_res(pfit_pkg::KIND_SET, slot >= 0, 0, 0, 0, 0, 1'b1);
      end
      pfit_pkg::ACT_CLEAR, pfit_pkg::ACT_CLEAR_ALL: begin
        for (int i = 0; i < 8; i++)
          if (c.action == pfit_pkg::ACT_CLEAR_ALL || (tab_act[i] && tab_id[i] == c.id))
            tab_act[i] = 1'b0;
        push_res(pfit_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 1'b1);
      end
      default: begin
        for (int i = 0; i < 8; i++) begin
          if (tab_act[i] && (tab_sent[i] == 0 || c.now - tab_sent[i] >= tab_iv[i])) begin
            tab_sent[i] = (c.now != 0) ? c.now : 32'd1;
            if (tab_rem[i] != 0 && !tab_rem[i][31]) begin
              tab_rem[i]--;
              if (tab_rem[i] == 0) tab_act[i] = 1'b0;
            end
            push_res(pfit_pkg::KIND_TX, 0, tab_id[i], tab_ext[i], tab_len[i], tab_data[i],
                     1'b0);
          end
        end
        push_res(pfit_pkg::KIND_TICK_DONE, 0, 0, 0, 0, 0, 1'b1);
      end
    endcase
  endfunction

  // driver: bursts with gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.action <= pfit_pkg::ACT_SET;
      in_if.frame_id <= '0;
      in_if.extended_flag <= 1'b0;
      in_if.length_code <= '0;
      in_if.payload <= '0;
      in_if.period_ms <= '0;
      in_if.repeat_count <= '0;
      in_if.now_ms <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_table(cmd_q.pop_front());
        sent_cnt++;
      end
      if (in_if.valid && !in_if.ready) begin
        // hold beat
      end else if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.action <= cmd_q[0].action;
        in_if.frame_id <= cmd_q[0].id;
        in_if.extended_flag <= cmd_q[0].ext;
        in_if.length_code <= cmd_q[0].len;
        in_if.payload <= cmd_q[0].data;
        in_if.period_ms <= cmd_q[0].interval;
        in_if.repeat_count <= cmd_q[0].rpt;
        in_if.now_ms <= cmd_q[0].now;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 25);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 64) % 3)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= (stall_phase % 7) < 3;
      endcase
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pfit_pkg::res_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected result beat kind=%0d", $time, out_if.result_kind);
        errors++;
      end else begin
        e = exp_q.pop_front();
        if (out_if.result_kind !== e.kind || out_if.accepted !== e.acc ||
            out_if.tx_id !== e.id || out_if.tx_extended !== e.ext ||
            out_if.tx_length !== e.len || out_if.tx_payload !== e.data ||
            out_if.active_jobs !== e.cnt || out_if.last_of_run !== e.last) begin
          $display("%0t: mismatch exp k=%0d a=%0d id=%h x=%0d l=%0d d=%h n=%0d last=%0d",
                   $time, e.kind, e.acc, e.id, e.ext, e.len, e.data, e.cnt, e.last);
          $display("%0t:          got k=%0d a=%0d id=%h x=%0d l=%0d d=%h n=%0d last=%0d",
                   $time, out_if.result_kind, out_if.accepted, out_if.tx_id,
                   out_if.tx_extended, out_if.tx_length, out_if.tx_payload,
                   out_if.active_jobs, out_if.last_of_run);
          errors++;
        end
      end
    end
  end

  logic [28:0] id_pool[6];
  int          queued = 0;

  function automatic void add_cmd(pfit_pkg::action_e a, logic [28:0] id, logic ext,
                                  logic [3:0] len, logic [63:0] d, logic [31:0] iv,
                                  logic [31:0] rpt, logic [31:0] now);
    job_cmd_t c;
    c.action = a; c.id = id; c.ext = ext; c.len = len; c.data = d;
    c.interval = iv; c.rpt = rpt; c.now = now;
    cmd_q.push_back(c);
    queued++;
  endfunction

  task automatic drain_and_config(logic [15:0] v);
    while (sent_cnt < queued || exp_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    min_iv = v;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int n, logic [31:0] now0);
    logic [31:0] now;
    logic [63:0] d;
    int pick;
    now = now0;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 19);
      d = {$urandom, $urandom};
      if (pick < 6)
        add_cmd(pfit_pkg::ACT_SET,
                ($urandom_range(0, 4) == 0) ? 29'($urandom) : id_pool[$urandom_range(0, 5)],
                1'($urandom), 4'($urandom), d,
                ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 60),
                ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 6) - 2, 0);
      else if (pick < 8)
        add_cmd(pfit_pkg::ACT_CLEAR, id_pool[$urandom_range(0, 5)], 0, 0, 0, 0, 0, 0);
      else if (pick < 9)
        add_cmd(pfit_pkg::ACT_CLEAR_ALL, 29'($urandom), 1'($urandom), 4'($urandom), d,
                $urandom, $urandom, $urandom);
      else begin
        now = now + (($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 25));
        add_cmd(pfit_pkg::ACT_TICK, 29'($urandom), 1'($urandom), 4'($urandom), d,
                $urandom, $urandom, now);
      end
    end
  endtask

  initial begin
    cfg_if.valid = 1'b0; cfg_if.data = 0;
    min_iv = pfit_pkg::MinIntervalRst;
    for (int i = 0; i < 8; i++) tab_act[i] = 1'b0;
    for (int i = 0; i < 6; i++) id_pool[i] = 29'($urandom);
    id_pool[0] = 29'h1FFFFFFF; id_pool[1] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, min clamp, never-sent mark, full table, counts
    add_cmd(pfit_pkg::ACT_SET, 29'h1FFFFFFF, 1, 4'hF, '1, 0, 2, 0);
    add_cmd(pfit_pkg::ACT_SET, 0, 0, 0, '1, 32'hFFFFFFFF, 32'h80000000, 0);
    add_cmd(pfit_pkg::ACT_SET, 29'h123, 1, 3, 64'h0123456789ABCDEF, 5, 32'h7FFFFFFF, 0);
    add_cmd(pfit_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0);
    add_cmd(pfit_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 9);
    add_cmd(pfit_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 10);
    add_cmd(pfit_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF);
    add_cmd(pfit_pkg::ACT_SET, 29'h123, 0, 8, '1, 20, 1, 0);
    add_cmd(pfit_pkg::ACT_SET, 29'h124, 0, 1, '1, 20, 0, 0);
    for (int i = 0; i < 6; i++)
      add_cmd(pfit_pkg::ACT_SET, 29'(29'h200 + i), 0, 2, '1, 10, -1, 0);
    add_cmd(pfit_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 100);
    add_cmd(pfit_pkg::ACT_CLEAR, 29'h5555, 0, 0, 0, 0, 0, 0);
    add_cmd(pfit_pkg::ACT_CLEAR, 29'h200, 1, 0, 0, 0, 0, 0);
    add_cmd(pfit_pkg::ACT_CLEAR_ALL, 0, 0, 0, 0, 0, 0, 0);
    add_cmd(pfit_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 200);
    drain_and_config(16'd0);
    add_cmd(pfit_pkg::ACT_SET, 29'h77, 0, 4, 64'hAAAA5555AAAA5555, 0, 3, 0);
    add_cmd(pfit_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 5);
    add_cmd(pfit_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 5);
    add_cmd(pfit_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 5);
    random_phase(110, 1000);
    drain_and_config(16'hFFFF);
    random_phase(100, 32'hFFFFFF00);
    drain_and_config(16'd1);
    random_phase(110, 50);
    drain_and_config(16'($urandom_range(2, 40)));
    random_phase(110, $urandom);
    while (sent_cnt < queued || exp_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/pfit_pkg.sv
rtl/core/pfit_if.sv
rtl/core/pfit_front.sv
rtl/core/pfit_queue.sv
rtl/core/pfit_back.sv
rtl/core/periodic_frame_injection_table_top.sv
rtl/core/pfit_checker.sv
tb/sv/periodic_frame_injection_table_top_tb.sv
